FILE: sv/wrs_pkg.sv
// Package with the payload types, sequencer states and fixed widths of the statistics bank.
`timescale 1ns / 1ps
package wrs_pkg;

  localparam int unsigned VAL_W = 48;
  localparam int unsigned SD_W = 47;
  localparam int unsigned CNT_W = 32;
  localparam int unsigned SUM_W = 64;
  localparam int unsigned CHN_W = 3;
  localparam int unsigned MUL_CHUNK_W = 16;
  localparam int unsigned MUL_STEPS = VAL_W / MUL_CHUNK_W;
  localparam int unsigned DIV_N_W = 64;
  localparam int unsigned DIV_D_W = 32;
  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_CLEAR = 1'b1;
  localparam logic [SD_W-1:0] SD_MAX = '1;

  typedef struct packed {
    logic operation;
    logic [CHN_W-1:0] channel;
    logic signed [VAL_W-1:0] sample_value;
    logic value_present;
  } in_item_t;

  typedef struct packed {
    logic [CHN_W-1:0] result_channel;
    logic [CNT_W-1:0] result_count;
    logic signed [VAL_W-1:0] result_mean;
    logic [SD_W-1:0] result_stddev;
    logic result_ready;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_VDIV,
    ST_SQRT,
    ST_EMIT,
    ST_UDIV,
    ST_MUL
  } wrs_state_e;

endpackage

FILE: sv/wrs_div.sv
// Restoring divider that produces one quotient bit per cycle.
`timescale 1ns / 1ps
module wrs_div (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  logic [wrs_pkg::DIV_N_W-1:0] dividend_i,
  input  logic [wrs_pkg::DIV_D_W-1:0] divisor_i,
  output logic done_o,
  output logic [wrs_pkg::DIV_N_W-1:0] quotient_o
);

  localparam int unsigned CW = $clog2(wrs_pkg::DIV_N_W + 1);

  logic busy_q, busy_d, done_q, done_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [wrs_pkg::DIV_D_W:0] rem_q, rem_d, shifted;
  logic [wrs_pkg::DIV_N_W-1:0] quo_q, quo_d;
  logic [wrs_pkg::DIV_D_W-1:0] dvs_q, dvs_d;
  logic fits;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d = cnt_q;
    rem_d = rem_q;
    quo_d = quo_q;
    dvs_d = dvs_q;
    shifted = {rem_q[wrs_pkg::DIV_D_W-1:0], quo_q[wrs_pkg::DIV_N_W-1]};
    fits = shifted >= {1'b0, dvs_q};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d = CW'(wrs_pkg::DIV_N_W);
      rem_d = '0;
      quo_d = dividend_i;
      dvs_d = divisor_i;
    end else if (busy_q) begin
      rem_d = fits ? shifted - {1'b0, dvs_q} : shifted;
      quo_d = {quo_q[wrs_pkg::DIV_N_W-2:0], fits};
      cnt_d = cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign done_o = done_q;
  assign quotient_o = quo_q;

endmodule

FILE: sv/wrs_sqrt.sv
// Digit-by-digit square root of a variance scaled by the fraction bits, two radicand bits per cycle.
`timescale 1ns / 1ps
module wrs_sqrt #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  logic [wrs_pkg::SUM_W-1:0] value_i,
  output logic done_o,
  output logic [wrs_pkg::SD_W-1:0] root_o
);

  localparam int unsigned RAD_W = wrs_pkg::SUM_W + FRAC_BITS + (FRAC_BITS % 2);
  localparam int unsigned RT_W = RAD_W / 2;
  localparam int unsigned REM_W = RT_W + 4;
  localparam int unsigned CW = $clog2(RT_W + 1);

  logic busy_q, busy_d, done_q, done_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [RAD_W-1:0] rad_q, rad_d;
  logic [RT_W-1:0] root_q, root_d;
  logic [REM_W-1:0] rem_q, rem_d, r2, trial;
  logic [63:0] root64;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d = cnt_q;
    rad_d = rad_q;
    root_d = root_q;
    rem_d = rem_q;
    r2 = {rem_q[REM_W-3:0], rad_q[RAD_W-1 -: 2]};
    trial = REM_W'({root_q, 2'b01});
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d = CW'(RT_W);
      rad_d = RAD_W'(value_i) << FRAC_BITS;
      root_d = '0;
      rem_d = '0;
    end else if (busy_q) begin
      rad_d = rad_q << 2;
      if (r2 >= trial) begin
        rem_d = r2 - trial;
        root_d = {root_q[RT_W-2:0], 1'b1};
      end else begin
        rem_d = r2;
        root_d = {root_q[RT_W-2:0], 1'b0};
      end
      cnt_d = cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q <= rad_d;
    root_q <= root_d;
    rem_q <= rem_d;
  end

  assign root64 = 64'(root_q);
  assign root_o = (root64 > 64'(wrs_pkg::SD_MAX)) ? wrs_pkg::SD_MAX : root64[wrs_pkg::SD_W-1:0];
  assign done_o = done_q;

endmodule

FILE: sv/wrs_mul.sv
// Multiplier that forms a 48 by 48 bit product from 16 bit slices, one slice per cycle.
`timescale 1ns / 1ps
module wrs_mul (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  logic [wrs_pkg::VAL_W-1:0] a_i,
  input  logic [wrs_pkg::VAL_W-1:0] b_i,
  output logic done_o,
  output logic [2*wrs_pkg::VAL_W-1:0] product_o
);

  localparam int unsigned W = wrs_pkg::VAL_W;
  localparam int unsigned CK = wrs_pkg::MUL_CHUNK_W;
  localparam int unsigned PW = W + CK;
  localparam int unsigned CW = $clog2(wrs_pkg::MUL_STEPS + 1);

  logic busy_q, busy_d, done_q, done_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [W-1:0] a_q, a_d, b_q, b_d;
  logic [2*W-1:0] acc_q, acc_d;
  logic [PW-1:0] part, hi;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d = cnt_q;
    a_d = a_q;
    b_d = b_q;
    acc_d = acc_q;
    part = PW'(a_q) * PW'(b_q[CK-1:0]);
    hi = PW'(acc_q[2*W-1:W]) + part;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d = CW'(wrs_pkg::MUL_STEPS);
      a_d = a_i;
      b_d = b_i;
      acc_d = '0;
    end else if (busy_q) begin
      acc_d = {hi, acc_q[W-1:CK]};
      b_d = b_q >> CK;
      cnt_d = cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q <= a_d;
    b_q <= b_d;
    acc_q <= acc_d;
  end

  assign done_o = done_q;
  assign product_o = acc_q;

endmodule

FILE: sv/welford_running_stats_bank_core.sv
// Top level of the per-channel running mean and standard deviation bank.
`timescale 1ns / 1ps
// Each transaction names a channel, reports that channel's count, mean, sample standard
// deviation and ready flag as they stood before it, then applies a Welford update with
// the value when one is present and the channel exists, or clears every channel. One
// transaction is handled at a time: in_stall_o is high from acceptance until the update
// is written. The snapshot needs a restoring division and a square root, both skipped
// below two samples; the update needs another division and a multiply. The result sits
// in an output register, so the block finishes the update while it waits to be taken.
module welford_running_stats_bank_core #(
  parameter int unsigned CHANNELS = 8,
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cfg_write_i,
  input  logic [wrs_pkg::CNT_W-1:0] cfg_wdata_i,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  wrs_pkg::in_item_t in_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output wrs_pkg::out_item_t out_data_o
);

  localparam int unsigned IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned VW = wrs_pkg::VAL_W;
  localparam int unsigned CNT_W = wrs_pkg::CNT_W;
  localparam int unsigned SUM_W = wrs_pkg::SUM_W;

  wrs_pkg::wrs_state_e state_q, state_d;

  logic [CNT_W-1:0] cnt_mem_q [CHANNELS];
  logic signed [VW-1:0] mean_mem_q [CHANNELS];
  logic [SUM_W-1:0] sum_mem_q [CHANNELS];
  logic [CNT_W-1:0] thresh_q;

  logic op_q, present_q, ok_q;
  logic [wrs_pkg::CHN_W-1:0] ch_q;
  logic signed [VW-1:0] x_q, mean_q, mean_new_q;
  logic [CNT_W-1:0] cnt_q, n_q;
  logic [SUM_W-1:0] sum_q;
  logic [wrs_pkg::SD_W-1:0] sd_q;
  logic [VW-1:0] ad_q;
  logic [VW-1:0] ad2;
  logic neg_q;

  wrs_pkg::out_item_t out_q;
  logic out_valid_q;

  logic accept, ok_in, emit_load;
  logic [IDX_W-1:0] in_idx, idx;
  logic [CNT_W-1:0] cnt_rd, n_next;
  logic signed [VW-1:0] mean_rd;
  logic [SUM_W-1:0] sum_rd;

  logic div_start, div_done, sqrt_start, sqrt_done, mul_start_q, mul_done;
  logic [wrs_pkg::DIV_N_W-1:0] div_n, quotient;
  logic [wrs_pkg::DIV_D_W-1:0] div_d;
  logic [wrs_pkg::SD_W-1:0] root;
  logic [2*VW-1:0] product, prod_sh;
  logic [SUM_W-1:0] term;
  logic [SUM_W:0] sum_ext;
  logic [SUM_W-1:0] sum_new;

  logic signed [VW:0] d_full, d2_full;
  logic signed [VW-1:0] mean_upd;

  assign in_idx = IDX_W'(in_data_i.channel);
  assign idx = IDX_W'(ch_q);
  assign ok_in = 32'(in_data_i.channel) < CHANNELS;
  assign cnt_rd = ok_in ? cnt_mem_q[in_idx] : '0;
  assign mean_rd = ok_in ? mean_mem_q[in_idx] : '0;
  assign sum_rd = ok_in ? sum_mem_q[in_idx] : '0;
  assign accept = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != wrs_pkg::ST_IDLE);

  assign n_next = (cnt_q == '1) ? cnt_q : cnt_q + CNT_W'(1);
  assign d_full = (VW + 1)'(x_q) - (VW + 1)'(mean_q);
  assign mean_upd = neg_q ? mean_q - $signed(quotient[VW-1:0])
                          : mean_q + $signed(quotient[VW-1:0]);
  assign d2_full = (VW + 1)'(x_q) - (VW + 1)'(mean_new_q);

  assign prod_sh = product >> FRAC_BITS;
  assign term = (|prod_sh[2*VW-1:SUM_W]) ? '1 : prod_sh[SUM_W-1:0];
  assign sum_ext = {1'b0, sum_q} + {1'b0, term};
  assign sum_new = sum_ext[SUM_W] ? '1 : sum_ext[SUM_W-1:0];

  always_comb begin
    state_d = state_q;
    div_start = 1'b0;
    sqrt_start = 1'b0;
    div_n = 64'(sum_rd);
    div_d = cnt_rd - CNT_W'(1);
    emit_load = 1'b0;
    case (state_q)
      wrs_pkg::ST_IDLE: begin
        if (accept) begin
          if (cnt_rd >= CNT_W'(2)) begin
            div_start = 1'b1;
            state_d = wrs_pkg::ST_VDIV;
          end else begin
            state_d = wrs_pkg::ST_EMIT;
          end
        end
      end
      wrs_pkg::ST_VDIV: begin
        if (div_done) begin
          sqrt_start = 1'b1;
          state_d = wrs_pkg::ST_SQRT;
        end
      end
      wrs_pkg::ST_SQRT: begin
        if (sqrt_done) begin
          state_d = wrs_pkg::ST_EMIT;
        end
      end
      wrs_pkg::ST_EMIT: begin
        if (!out_valid_q || !out_stall_i) begin
          emit_load = 1'b1;
          if (op_q == wrs_pkg::OP_SAMPLE && ok_q && present_q) begin
            div_n = 64'(d_full[VW] ? -d_full : d_full);
            div_d = n_next;
            div_start = 1'b1;
            state_d = wrs_pkg::ST_UDIV;
          end else begin
            state_d = wrs_pkg::ST_IDLE;
          end
        end
      end
      wrs_pkg::ST_UDIV: begin
        if (div_done) begin
          state_d = wrs_pkg::ST_MUL;
        end
      end
      wrs_pkg::ST_MUL: begin
        if (!mul_start_q && mul_done) begin
          state_d = wrs_pkg::ST_IDLE;
        end
      end
      default: state_d = wrs_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= wrs_pkg::ST_IDLE;
      thresh_q <= 32'd300;
      out_valid_q <= 1'b0;
      mul_start_q <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
        cnt_mem_q[i] <= '0;
        mean_mem_q[i] <= '0;
        sum_mem_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      mul_start_q <= (state_q == wrs_pkg::ST_UDIV) && div_done;
      if (cfg_write_i) begin
        thresh_q <= cfg_wdata_i;
      end
      if (emit_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (emit_load && op_q == wrs_pkg::OP_CLEAR) begin
        for (int i = 0; i < CHANNELS; i++) begin
          cnt_mem_q[i] <= '0;
          mean_mem_q[i] <= '0;
          sum_mem_q[i] <= '0;
        end
      end else if (state_q == wrs_pkg::ST_MUL && !mul_start_q && mul_done) begin
        cnt_mem_q[idx] <= n_q;
        mean_mem_q[idx] <= mean_new_q;
        sum_mem_q[idx] <= sum_new;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q <= in_data_i.operation;
      ch_q <= in_data_i.channel;
      x_q <= in_data_i.sample_value;
      present_q <= in_data_i.value_present;
      ok_q <= ok_in;
      cnt_q <= cnt_rd;
      mean_q <= mean_rd;
      sum_q <= sum_rd;
      sd_q <= '0;
    end
    if (state_q == wrs_pkg::ST_SQRT && sqrt_done) begin
      sd_q <= root;
    end
    if (emit_load) begin
      out_q.result_channel <= ch_q;
      out_q.result_count <= cnt_q;
      out_q.result_mean <= mean_q;
      out_q.result_stddev <= sd_q;
      out_q.result_ready <= (cnt_q >= thresh_q);
      n_q <= n_next;
      neg_q <= d_full[VW];
      ad_q <= div_n[VW-1:0];
    end
    if (state_q == wrs_pkg::ST_UDIV && div_done) begin
      mean_new_q <= mean_upd;
    end
  end

  always_comb begin
    if (d2_full[VW]) begin
      ad2 = VW'(-d2_full);
    end else begin
      ad2 = d2_full[VW-1:0];
    end
  end

  wrs_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_n),
    .divisor_i  (div_d),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  wrs_sqrt #(
    .FRAC_BITS (FRAC_BITS)
  ) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_start),
    .value_i (quotient),
    .done_o  (sqrt_done),
    .root_o  (root)
  );

  wrs_mul u_mul (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (mul_start_q),
    .a_i       (ad_q),
    .b_i       (ad2),
    .done_o    (mul_done),
    .product_o (product)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o = out_q;

endmodule

FILE: sv/wrs_checker.sv
// Port-level checker for the statistics bank, bound to the top level.
`timescale 1ns / 1ps
module wrs_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_stall_o,
  input logic out_valid_o,
  input logic out_stall_i
);

  // A stalled result stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("Stalled result was withdrawn.");

  // An accepted transaction keeps the input side stalled in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("Input not stalled after a transaction was accepted.");

  // A new result only appears while a transaction is in work.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("Result appeared with no transaction in work.");

endmodule

bind welford_running_stats_bank_core wrs_checker u_wrs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i)
);
